// ----- rtl/quaternion_to_euler_assert.svh -----
// Assertion macros for the quaternion to Euler angle block
`ifndef QUATERNION_TO_EULER_ASSERT_SVH
`define QUATERNION_TO_EULER_ASSERT_SVH

// same-cycle implication
`define QTE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("quaternion_to_euler: assertion failed");

// next-cycle implication
`define QTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("quaternion_to_euler: assertion failed");

`endif

// ----- rtl/qte_pkg.sv -----
package qte_pkg;

  localparam int QUAT_WIDTH_DEF  = 16;
  localparam int ANGLE_WIDTH_DEF = 16;

  localparam int VAL_W        = 37;
  localparam int RT_W         = 62;
  localparam int NORM_W       = 57;
  localparam int CW           = 60;
  localparam int ZW           = 33;
  localparam int SQRT_STEPS   = 31;
  localparam int NORM_STEPS   = 6;
  localparam int CORDIC_STEPS = 30;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [ZW-1:0]    ang_t;

  localparam val_t ONE_Q30 = 37'sd1073741824;
  localparam logic [RT_W-1:0] ONE_Q60 = 62'd1 << 60;
  localparam ang_t TURN_HALF    = 33'sd2147483648;
  localparam ang_t TURN_QUARTER = 33'sd1073741824;

  // atan(2^-i), full turn = 2^32
  localparam logic [29:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
    30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001};

  typedef struct packed {
    val_t s;
    val_t ry;
    val_t rx;
    val_t yy;
    val_t yx;
  } front_t;

  typedef struct packed {
    logic [RT_W-1:0] v;
    logic [RT_W-1:0] res;
    front_t          pl;
  } sq_t;

  typedef struct packed {
    logic              sx;
    logic              sy;
    logic              xzero;
    logic              yzero;
    logic [NORM_W-1:0] ax;
    logic [NORM_W-1:0] ay;
  } lane_t;

  typedef lane_t [2:0] lane3_t;

  typedef struct packed {
    logic                 sx;
    logic                 sy;
    logic                 xzero;
    logic                 yzero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    ang_t                 z;
  } cord_t;

  typedef cord_t [2:0] cord3_t;

  function automatic lane_t make_lane(input val_t y, input val_t x);
    lane_t            l;
    logic [VAL_W-1:0] ux;
    logic [VAL_W-1:0] uy;
    ux = x[VAL_W-1] ? VAL_W'(-x) : VAL_W'(x);
    uy = y[VAL_W-1] ? VAL_W'(-y) : VAL_W'(y);
    l.sx    = x[VAL_W-1];
    l.sy    = y[VAL_W-1];
    l.xzero = (x == '0);
    l.yzero = (y == '0);
    l.ax    = NORM_W'(ux);
    l.ay    = NORM_W'(uy);
    return l;
  endfunction

  function automatic cord_t init_cord(input lane_t l);
    cord_t c;
    c.sx    = l.sx;
    c.sy    = l.sy;
    c.xzero = l.xzero;
    c.yzero = l.yzero;
    c.x     = $signed({{(CW-NORM_W){1'b0}}, l.ax});
    c.y     = $signed({{(CW-NORM_W){1'b0}}, l.ay});
    c.z     = '0;
    return c;
  endfunction

  // first-quadrant angle mapped back to the operands' signs
  function automatic ang_t lane_angle(input cord_t c);
    ang_t q;
    ang_t a;
    if (c.z < 0) begin
      q = '0;
    end else if (c.z > TURN_QUARTER) begin
      q = TURN_QUARTER;
    end else begin
      q = c.z;
    end
    if (c.yzero) begin
      q = '0;
    end else if (c.xzero) begin
      q = TURN_QUARTER;
    end
    a = c.sx ? (TURN_HALF - q) : q;
    if (c.sy) begin
      a = -a;
    end
    return a;
  endfunction

endpackage

// ----- rtl/qte_sqrt_cell.sv -----
module qte_sqrt_cell #(
  parameter int B = 0
) (
  input  logic         clk,
  input  logic         en,
  input  qte_pkg::sq_t d_in,
  output qte_pkg::sq_t d_out
);
  import qte_pkg::*;

  localparam logic [RT_W-1:0] BITV = RT_W'(1) << (2 * B);

  logic [RT_W-1:0] trial;
  sq_t             q_nxt;
  sq_t             q_r;

  always_comb begin
    q_nxt = d_in;
    trial = d_in.res + BITV;
    if (d_in.v >= trial) begin
      q_nxt.v   = d_in.v - trial;
      q_nxt.res = (d_in.res >> 1) + BITV;
    end else begin
      q_nxt.res = d_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;

endmodule

// ----- rtl/qte_norm_cell.sv -----
module qte_norm_cell #(
  parameter int SH = 1
) (
  input  logic            clk,
  input  logic            en,
  input  qte_pkg::lane3_t d_in,
  output qte_pkg::lane3_t d_out
);
  import qte_pkg::*;

  localparam logic [NORM_W-1:0] LIM = NORM_W'(1) << (NORM_W - SH);

  lane3_t q_nxt;
  lane3_t q_r;

  always_comb begin
    q_nxt = d_in;
    for (int l = 0; l < 3; l++) begin
      if (((d_in[l].ax > d_in[l].ay) ? d_in[l].ax : d_in[l].ay) < LIM) begin
        q_nxt[l].ax = d_in[l].ax << SH;
        q_nxt[l].ay = d_in[l].ay << SH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;

endmodule

// ----- rtl/qte_cordic_cell.sv -----
module qte_cordic_cell #(
  parameter int I = 0
) (
  input  logic            clk,
  input  logic            en,
  input  qte_pkg::cord3_t d_in,
  output qte_pkg::cord3_t d_out
);
  import qte_pkg::*;

  localparam ang_t ATAN_I = $signed({3'b000, ATAN_TAB[I]});

  cord3_t q_nxt;
  cord3_t q_r;

  always_comb begin
    q_nxt = d_in;
    for (int l = 0; l < 3; l++) begin
      if (!d_in[l].y[CW-1]) begin
        q_nxt[l].x = d_in[l].x + (d_in[l].y >>> I);
        q_nxt[l].y = d_in[l].y - (d_in[l].x >>> I);
        q_nxt[l].z = d_in[l].z + ATAN_I;
      end else begin
        q_nxt[l].x = d_in[l].x - (d_in[l].y >>> I);
        q_nxt[l].y = d_in[l].y + (d_in[l].x >>> I);
        q_nxt[l].z = d_in[l].z - ATAN_I;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;

endmodule

// ----- rtl/quaternion_to_euler.sv -----
// Attitude quaternion to Z-Y-X Euler angles (pitch, roll, yaw) in degrees.
// Input channel: in_valid / in_stall with in_quat_w (scalar) and in_quat_x/y/z,
// signed Q2.(QUAT_WIDTH-2). Result channel: out_valid / out_stall with
// out_pitch_deg in signed Q8.(ANGLE_WIDTH-9), out_roll_deg and out_yaw_deg in
// signed Q9.(ANGLE_WIDTH-9) and out_asin_clipped, set when the pitch sine was
// saturated to unit magnitude. One result per item, in order. A new item is
// taken every clock while in_stall is low. The pipeline holds three front stages
// (products, sums, sine square), 31 square root cells, 6 normalize cells,
// 30 CORDIC cells and one degree scaling stage before the output register.
// The pipeline moves as one: when out_valid is high and out_stall is held,
// every stage freezes, the output holds its item and in_stall is raised.
// Synchronous reset drops all stage valid bits; items in flight are lost.
module quaternion_to_euler #(
  parameter int QUAT_WIDTH  = qte_pkg::QUAT_WIDTH_DEF,
  parameter int ANGLE_WIDTH = qte_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [QUAT_WIDTH-1:0]  in_quat_w,
  input  logic signed [QUAT_WIDTH-1:0]  in_quat_x,
  input  logic signed [QUAT_WIDTH-1:0]  in_quat_y,
  input  logic signed [QUAT_WIDTH-1:0]  in_quat_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ANGLE_WIDTH-2:0] out_pitch_deg,
  output logic signed [ANGLE_WIDTH-1:0] out_roll_deg,
  output logic signed [ANGLE_WIDTH-1:0] out_yaw_deg,
  output logic                          out_asin_clipped
);
  import qte_pkg::*;

  localparam int QF  = QUAT_WIDTH - 2;
  localparam int PW  = 2 * QUAT_WIDTH;
  localparam int MSH = 2 * QF - 30;
  localparam int LSH = (MSH < 0) ? -MSH : 0;
  localparam int RSH = (MSH > 0) ? MSH : 0;
  localparam int XW  = PW + LSH;
  localparam int AF  = ANGLE_WIDTH - 9;
  localparam int NST = 3 + SQRT_STEPS + NORM_STEPS + CORDIC_STEPS + 1;

  localparam logic [31:0] DEG_K     = 32'(360) << AF;
  localparam logic [31:0] PITCH_LIM = 32'(90) << AF;
  localparam logic [31:0] ROLL_LIM  = 32'(180) << AF;
  localparam logic signed [ANGLE_WIDTH-2:0] PITCH_LIM_S = (ANGLE_WIDTH-1)'(PITCH_LIM);
  localparam logic signed [ANGLE_WIDTH-1:0] ROLL_LIM_S  = ANGLE_WIDTH'(ROLL_LIM);

  function automatic val_t scl(input logic signed [PW-1:0] p);
    logic signed [XW-1:0] e;
    e = XW'(p);
    e = e <<< LSH;
    e = e >>> RSH;
    return val_t'(e);
  endfunction

  logic adv;
  logic [NST-1:0] vld_r;
  logic [NST-1:1] clp_r;

  logic signed [PW-1:0] p_wy_r, p_xz_r, p_yz_r, p_wx_r, p_xx_r;
  logic signed [PW-1:0] p_yy_r, p_xy_r, p_wz_r, p_zz_r;

  val_t   s_raw;
  val_t   s_sat;
  logic   clip_nxt;
  front_t front_nxt;
  front_t front_r;

  logic [30:0]     sabs;
  logic [RT_W-1:0] s2;
  sq_t             sq0_r;

  sq_t    sq_d [SQRT_STEPS+1];
  lane3_t ln_d [NORM_STEPS+1];
  cord3_t cd_d [CORDIC_STEPS+1];

  ang_t        ang   [3];
  logic [31:0] mag   [3];
  logic [63:0] prod_r [3];
  logic [2:0]  neg_r;

  logic [64:0]                   rnd   [3];
  logic [31:0]                   dmag  [3];
  logic signed [ANGLE_WIDTH-1:0] deg_v [3];

  logic                          out_valid_r;
  logic signed [ANGLE_WIDTH-2:0] out_pitch_deg_r;
  logic signed [ANGLE_WIDTH-1:0] out_roll_deg_r;
  logic signed [ANGLE_WIDTH-1:0] out_yaw_deg_r;
  logic                          out_asin_clipped_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // valid and clip flag track the data through the row of cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NST-2:0], in_valid};
      out_valid_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      clp_r <= {clp_r[NST-2:1], clip_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_wy_r <= in_quat_w * in_quat_y;
      p_xz_r <= in_quat_x * in_quat_z;
      p_yz_r <= in_quat_y * in_quat_z;
      p_wx_r <= in_quat_w * in_quat_x;
      p_xx_r <= in_quat_x * in_quat_x;
      p_yy_r <= in_quat_y * in_quat_y;
      p_xy_r <= in_quat_x * in_quat_y;
      p_wz_r <= in_quat_w * in_quat_z;
      p_zz_r <= in_quat_z * in_quat_z;
    end
  end

  always_comb begin
    s_raw = (scl(p_wy_r) - scl(p_xz_r)) <<< 1;
    clip_nxt = (s_raw > ONE_Q30) || (s_raw < -ONE_Q30);
    if (s_raw > ONE_Q30) begin
      s_sat = ONE_Q30;
    end else if (s_raw < -ONE_Q30) begin
      s_sat = -ONE_Q30;
    end else begin
      s_sat = s_raw;
    end
    front_nxt.s  = s_sat;
    front_nxt.ry = (scl(p_yz_r) + scl(p_wx_r)) <<< 1;
    front_nxt.rx = ONE_Q30 - ((scl(p_xx_r) + scl(p_yy_r)) <<< 1);
    front_nxt.yy = (scl(p_xy_r) + scl(p_wz_r)) <<< 1;
    front_nxt.yx = ONE_Q30 - ((scl(p_yy_r) + scl(p_zz_r)) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      front_r <= front_nxt;
    end
  end

  // cosine of pitch: sqrt(1 - s^2) in Q.30
  assign sabs = front_r.s[VAL_W-1] ? 31'(-front_r.s) : 31'(front_r.s);
  assign s2   = sabs * sabs;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq0_r.v   <= ONE_Q60 - s2;
      sq0_r.res <= '0;
      sq0_r.pl  <= front_r;
    end
  end

  assign sq_d[0] = sq0_r;

  for (genvar gk = 0; gk < SQRT_STEPS; gk++) begin : g_sqrt
    qte_sqrt_cell #(.B(SQRT_STEPS - 1 - gk)) u_cell (
      .clk   (clk),
      .en    (adv),
      .d_in  (sq_d[gk]),
      .d_out (sq_d[gk+1])
    );
  end

  assign ln_d[0][0] = make_lane(sq_d[SQRT_STEPS].pl.s, val_t'(sq_d[SQRT_STEPS].res));
  assign ln_d[0][1] = make_lane(sq_d[SQRT_STEPS].pl.ry, sq_d[SQRT_STEPS].pl.rx);
  assign ln_d[0][2] = make_lane(sq_d[SQRT_STEPS].pl.yy, sq_d[SQRT_STEPS].pl.yx);

  for (genvar gk = 0; gk < NORM_STEPS; gk++) begin : g_norm
    qte_norm_cell #(.SH(32 >> gk)) u_cell (
      .clk   (clk),
      .en    (adv),
      .d_in  (ln_d[gk]),
      .d_out (ln_d[gk+1])
    );
  end

  for (genvar gl = 0; gl < 3; gl++) begin : g_init
    assign cd_d[0][gl] = init_cord(ln_d[NORM_STEPS][gl]);
  end

  for (genvar gk = 0; gk < CORDIC_STEPS; gk++) begin : g_cordic
    qte_cordic_cell #(.I(gk)) u_cell (
      .clk   (clk),
      .en    (adv),
      .d_in  (cd_d[gk]),
      .d_out (cd_d[gk+1])
    );
  end

  // turn fraction to degrees
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ang[l] = lane_angle(cd_d[CORDIC_STEPS][l]);
      mag[l] = ang[l][ZW-1] ? 32'(-ang[l]) : 32'(ang[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        prod_r[l] <= mag[l] * DEG_K;
        neg_r[l]  <= ang[l][ZW-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rnd[l]  = 65'(prod_r[l]) + (65'd1 << 31);
      dmag[l] = rnd[l][63:32];
      if (l == 0) begin
        if (dmag[l] > PITCH_LIM) begin
          dmag[l] = PITCH_LIM;
        end
      end else begin
        if (dmag[l] > ROLL_LIM) begin
          dmag[l] = ROLL_LIM;
        end
      end
      deg_v[l] = neg_r[l] ? -ANGLE_WIDTH'(dmag[l]) : ANGLE_WIDTH'(dmag[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pitch_deg_r    <= deg_v[0][ANGLE_WIDTH-2:0];
      out_roll_deg_r     <= deg_v[1];
      out_yaw_deg_r      <= deg_v[2];
      out_asin_clipped_r <= clp_r[NST-1];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pitch_deg    = out_pitch_deg_r;
  assign out_roll_deg     = out_roll_deg_r;
  assign out_yaw_deg      = out_yaw_deg_r;
  assign out_asin_clipped = out_asin_clipped_r;

`include "quaternion_to_euler_assert.svh"

  `QTE_ASSERT_IMPL(a_clip_pitch, clk, rst_n, out_valid_r && out_asin_clipped_r, (out_pitch_deg_r == PITCH_LIM_S) || (out_pitch_deg_r == -PITCH_LIM_S))
  `QTE_ASSERT_IMPL(a_roll_range, clk, rst_n, out_valid_r, (out_roll_deg_r <= ROLL_LIM_S) && (out_roll_deg_r >= -ROLL_LIM_S))
  `QTE_ASSERT_IMPL(a_yaw_range, clk, rst_n, out_valid_r, (out_yaw_deg_r <= ROLL_LIM_S) && (out_yaw_deg_r >= -ROLL_LIM_S))
  `QTE_ASSERT_NEXT(a_freeze, clk, rst_n, !adv, $stable(vld_r) && $stable(out_pitch_deg_r))

endmodule
